// File: src/websocket_frame_deframer_defines.svh
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, checked out of reset
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// File: src/wsd_pkg.sv
package wsd_pkg;

  localparam logic [1:0] STATUS_DATA    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [1:0]  status;
    logic [3:0]  frame_opcode;
    logic [15:0] payload_length;
  } res_t;

endpackage

// File: src/websocket_frame_deframer.sv
// WebSocket frame deframer: takes one received byte per request, parses the frame
// header (opcode, 7-bit or 16-bit length, 4-byte masking key) and returns each
// payload byte unmasked, flagging the last one; length code 127 and empty frames
// give one status-only result. Throughput is one byte per clock while nothing stalls: a
// byte sits in an input register, the header/unmask logic works on it combinationally
// and the result lands in an output register. A new byte is taken while a result
// waits, as long as the input register empties; it stalls only when a byte sits in
// the input register and the output register is held.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o,
  output logic [1:0]  status_o,
  output logic [3:0]  frame_opcode_o,
  output logic [15:0] payload_length_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       adv;
  logic       accept;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // the input stage moves on whenever the output slot is free or being taken
  assign adv        = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~adv;
  assign accept     = in_valid_i & ~in_stall_o;
  assign s1_valid_d = accept | (s1_valid_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= chunk_start_i;
    end
  end

  wsd_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (s1_valid_q & adv),
    .rx_byte_i     (s1_byte_q),
    .chunk_start_i (s1_start_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_valid_q & adv & res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign payload_byte_o   = out_res.payload_byte;
  assign last_of_frame_o  = out_res.last_of_frame;
  assign status_o         = out_res.status;
  assign frame_opcode_o   = out_res.frame_opcode;
  assign payload_length_o = out_res.payload_length;

  `WSD_ASSERT_NOW(a_status_only_shape,
    out_valid_o && (status_o == STATUS_EMPTY || status_o == STATUS_TOO_BIG),
    payload_byte_o == 8'h00 && last_of_frame_o)
  `WSD_ASSERT_NOW(a_too_big_no_length,
    out_valid_o && status_o == STATUS_TOO_BIG, payload_length_o == 16'd0)
  `WSD_ASSERT_NEXT(a_full_pipe_holds,
    s1_valid_q && out_valid_o && out_stall_i, s1_valid_q)

endmodule

// File: src/wsd_parse.sv
module wsd_parse
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] rx_byte_i,
  input  logic       chunk_start_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_EXT_HI = 3'd2;
  localparam logic [2:0] PH_EXT_LO = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_TOO_BIG = 7'd127;
  localparam logic [15:0] KEY_BYTES  = 16'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opc_q, opc_d;
  logic [15:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [15:0] idx_q, idx_d;

  always_comb begin
    logic [6:0]  code;
    logic [15:0] idx_inc;
    logic [7:0]  key_byte;
    logic        last;
    code     = rx_byte_i[6:0];
    idx_inc  = idx_q + 16'd1;
    key_byte = key_q[8 * (3 - idx_q[1:0]) +: 8];
    last     = (idx_inc >= len_q);

    phase_d = phase_q;
    opc_d   = opc_q;
    len_d   = len_q;
    key_d   = key_q;
    idx_d   = idx_q;

    res_valid_o          = 1'b0;
    res_o.payload_byte   = 8'h00;
    res_o.last_of_frame  = 1'b0;
    res_o.status         = STATUS_DATA;
    res_o.frame_opcode   = opc_q;
    res_o.payload_length = len_q;

    if (chunk_start_i) begin
      // a new chunk restarts header parsing and drops any frame in flight
      opc_d   = rx_byte_i[3:0];
      len_d   = 16'd0;
      key_d   = 32'd0;
      idx_d   = 16'd0;
      phase_d = PH_LEN;
    end else begin
      case (phase_q)
        PH_LEN: begin
          if (code == LEN_TOO_BIG) begin
            len_d                = 16'd0;
            phase_d              = PH_WAIT;
            res_valid_o          = 1'b1;
            res_o.last_of_frame  = 1'b1;
            res_o.status         = STATUS_TOO_BIG;
            res_o.payload_length = 16'd0;
          end else if (code == LEN_EXT16) begin
            phase_d = PH_EXT_HI;
          end else begin
            len_d   = {9'd0, code};
            idx_d   = 16'd0;
            phase_d = PH_MASK;
          end
        end
        PH_EXT_HI: begin
          len_d   = {rx_byte_i, 8'h00};
          phase_d = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          len_d   = {len_q[15:8], rx_byte_i};
          idx_d   = 16'd0;
          phase_d = PH_MASK;
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          idx_d = idx_inc;
          if (idx_inc >= KEY_BYTES) begin
            idx_d = 16'd0;
            if (len_q == 16'd0) begin
              phase_d             = PH_WAIT;
              res_valid_o         = 1'b1;
              res_o.last_of_frame = 1'b1;
              res_o.status        = STATUS_EMPTY;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          idx_d = idx_inc;
          if (last) begin
            phase_d = PH_WAIT;
          end
          res_valid_o         = 1'b1;
          res_o.payload_byte  = rx_byte_i ^ key_byte;
          res_o.last_of_frame = last;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      opc_q   <= 4'd0;
      len_q   <= 16'd0;
      key_q   <= 32'd0;
      idx_q   <= 16'd0;
    end else if (en_i) begin
      phase_q <= phase_d;
      opc_q   <= opc_d;
      len_q   <= len_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// File: src/wsd_out_reg.sv
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t res_o
);

  logic out_valid_q, out_valid_d;
  res_t res_q;

  // a held request stays until taken; a load only happens when the slot frees
  assign out_valid_d = load_i | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
